### src/dmx_bmd_pkg.sv
`default_nettype none
package dmx_bmd_pkg;

  localparam int unsigned LIMIT_BITS   = 16;
  localparam int unsigned TIMEOUT_BITS = 8;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned WIDTH_COUNT_BITS_DEFAULT = 16;

  localparam logic [LIMIT_BITS-1:0]   BREAK_MIN_RESET  = 16'd87;
  localparam logic [LIMIT_BITS-1:0]   BREAK_MAX_RESET  = 16'd210;
  localparam logic [TIMEOUT_BITS-1:0] MARK_TIMEOUT_RESET = 8'd20;

  localparam logic [1:0] REQ_EDGE       = 2'd0;
  localparam logic [1:0] REQ_WIDTH_TICK = 2'd1;
  localparam logic [1:0] REQ_MS_TICK    = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_BREAK_MIN    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BREAK_MAX    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MARK_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BREAK = 2'd1,
    ST_MARK  = 2'd2
  } detect_state_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0]   break_min;
    logic [LIMIT_BITS-1:0]   break_max;
    logic [TIMEOUT_BITS-1:0] mark_timeout;
  } cfg_regs_t;

  typedef struct packed {
    logic       receive_enable;
    logic       frame_start;
    logic       indicator;
    logic [1:0] detect_state;
  } result_t;

endpackage
`default_nettype wire

### src/dmx_bmd_cfg_regs.sv
`default_nettype none
module dmx_bmd_cfg_regs
  import dmx_bmd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_regs_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.break_min    <= BREAK_MIN_RESET;
      cfg.break_max    <= BREAK_MAX_RESET;
      cfg.mark_timeout <= MARK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BREAK_MIN:    cfg.break_min    <= cfg_data[LIMIT_BITS-1:0];
        CFG_BREAK_MAX:    cfg.break_max    <= cfg_data[LIMIT_BITS-1:0];
        CFG_MARK_TIMEOUT: cfg.mark_timeout <= cfg_data[TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/dmx_bmd_core.sv
`default_nettype none
module dmx_bmd_core
  import dmx_bmd_pkg::*;
#(
  parameter int unsigned WIDTH_COUNT_BITS = WIDTH_COUNT_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [1:0] req_type,
  input  wire logic       pin_level,
  input  wire cfg_regs_t  cfg,
  output result_t         result
);

  localparam int unsigned CMP_BITS =
    (WIDTH_COUNT_BITS > LIMIT_BITS) ? WIDTH_COUNT_BITS : LIMIT_BITS;

  detect_state_t               state, state_next;
  logic [WIDTH_COUNT_BITS-1:0] width_count, width_count_next;
  logic                        width_running, width_running_next;
  logic [TIMEOUT_BITS-1:0]     timeout_left, timeout_left_next;
  logic                        receive_flag, receive_flag_next;
  logic                        light_on, light_on_next;
  logic                        start;
  logic [CMP_BITS-1:0]         width_ext, min_ext, max_ext;

  assign width_ext = CMP_BITS'(width_count);
  assign min_ext   = CMP_BITS'(cfg.break_min);
  assign max_ext   = CMP_BITS'(cfg.break_max);

  always_comb begin
    state_next         = state;
    width_count_next   = width_count;
    width_running_next = width_running;
    timeout_left_next  = timeout_left;
    receive_flag_next  = receive_flag;
    light_on_next      = light_on;
    start              = 1'b0;
    case (req_type)
      REQ_EDGE: begin
        if (!(receive_flag && timeout_left != '0)) begin
          case (state)
            ST_IDLE: begin
              if (!pin_level) begin
                width_count_next   = '0;
                width_running_next = 1'b1;
                state_next         = ST_BREAK;
              end
            end
            ST_BREAK: begin
              if (pin_level && width_ext > min_ext && width_ext < max_ext) begin
                light_on_next     = 1'b1;
                state_next        = ST_MARK;
                start             = 1'b1;
                timeout_left_next = cfg.mark_timeout;
              end else begin
                state_next = ST_IDLE;
              end
              width_running_next = 1'b0;
            end
            ST_MARK: begin
              receive_flag_next = !pin_level && (timeout_left != '0);
              state_next        = ST_IDLE;
              light_on_next     = 1'b0;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      REQ_WIDTH_TICK: begin
        if (width_running && width_count != '1) begin
          width_count_next = width_count + 1'b1;
        end
      end
      REQ_MS_TICK: begin
        if (timeout_left != '0) begin
          timeout_left_next = timeout_left - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign result.receive_enable = receive_flag_next;
  assign result.frame_start    = start;
  assign result.indicator      = light_on_next;
  assign result.detect_state   = state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      width_count   <= '0;
      width_running <= 1'b0;
      timeout_left  <= '0;
      receive_flag  <= 1'b0;
      light_on      <= 1'b0;
    end else if (step) begin
      state         <= state_next;
      width_count   <= width_count_next;
      width_running <= width_running_next;
      timeout_left  <= timeout_left_next;
      receive_flag  <= receive_flag_next;
      light_on      <= light_on_next;
    end
  end

  a_running_in_break: assert property (@(posedge clk) disable iff (rst)
    width_running |-> state == ST_BREAK)
    else $error("width counter running outside break");

  a_light_in_mark: assert property (@(posedge clk) disable iff (rst)
    light_on == (state == ST_MARK))
    else $error("indicator disagrees with mark state");

  a_start_enters_mark: assert property (@(posedge clk) disable iff (rst)
    step && start |=> state == ST_MARK && timeout_left == $past(cfg.mark_timeout))
    else $error("frame start without mark entry");

  a_count_held: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(width_count) && $stable(timeout_left))
    else $error("state changed without a transfer");

endmodule
`default_nettype wire

### src/dmx_bmd_out_stage.sv
`default_nettype none
module dmx_bmd_out_stage
  import dmx_bmd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire result_t result,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= result;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_load_on_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid && out_data == $past(result))
    else $error("result not registered on transfer");

  a_no_double: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !in_valid |=> !out_valid)
    else $error("result repeated");

endmodule
`default_nettype wire

### src/dmx_break_mark_detector_top.sv
// DMX512 break / mark-after-break detector.
// Input channel (in_valid/in_ready): one event per transfer. req_type selects
// a pin edge (pin_level carries the sampled line level), a width timer tick or
// a millisecond tick. Every event yields exactly one result.
// Output channel (out_valid/out_ready): receive_enable, frame_start,
// indicator and detect_state as they stand after the event.
// Configuration channel (cfg_valid/cfg_ready): index 0 break_min_ticks,
// 1 break_max_ticks, 2 mark_timeout_ms; other indexes are ignored. cfg_ready
// is always high; write only while no event is in flight.
// out_valid rises in the cycle after the input transfer. Throughput: one
// event per cycle unless out_ready stalls, set by the single result register;
// the detector state updates in the same cycle the event is taken.
// Reset (rst, synchronous): state idle, counters and flags clear, registers
// back to 87 / 210 / 20, output register empty.
// When the receiver stalls, the pending result holds and in_ready drops;
// in_ready stays high while the result register is empty or being drained.
`default_nettype none
module dmx_break_mark_detector_top
  import dmx_bmd_pkg::*;
#(
  parameter int unsigned WIDTH_COUNT_BITS = WIDTH_COUNT_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                req_type,
  input  wire logic                      pin_level,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           receive_enable,
  output logic                           frame_start,
  output logic                           indicator,
  output logic [1:0]                     detect_state,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_regs_t cfg;
  result_t   result;
  result_t   out_data;

  dmx_bmd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dmx_bmd_core #(
    .WIDTH_COUNT_BITS (WIDTH_COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (in_valid && in_ready),
    .req_type  (req_type),
    .pin_level (pin_level),
    .cfg       (cfg),
    .result    (result)
  );

  dmx_bmd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign receive_enable = out_data.receive_enable;
  assign frame_start    = out_data.frame_start;
  assign indicator      = out_data.indicator;
  assign detect_state   = out_data.detect_state;

endmodule
`default_nettype wire

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmx_bmd_pkg::*;

  localparam int unsigned COUNT_BITS = WIDTH_COUNT_BITS_DEFAULT;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] req_type = REQ_EDGE;
  logic pin_level = 1'b1;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_BREAK_MIN;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  wire logic in_ready;
  wire logic out_valid;
  wire logic receive_enable;
  wire logic frame_start;
  wire logic indicator;
  wire logic [1:0] detect_state;
  wire logic cfg_ready;

  // Detector state as predicted on the input side
  detect_state_t fsm = ST_IDLE;
  logic [COUNT_BITS-1:0] width_cnt = '0;
  logic width_run = 1'b0;
  logic [TIMEOUT_BITS-1:0] tmo_left = '0;
  logic rx_flag = 1'b0;
  logic light = 1'b0;
  logic [LIMIT_BITS-1:0] brk_min = BREAK_MIN_RESET;
  logic [LIMIT_BITS-1:0] brk_max = BREAK_MAX_RESET;
  logic [TIMEOUT_BITS-1:0] mark_tmo = MARK_TIMEOUT_RESET;

  result_t status_q[$];
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;

  dmx_break_mark_detector_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .pin_level      (pin_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .receive_enable (receive_enable),
    .frame_start    (frame_start),
    .indicator      (indicator),
    .detect_state   (detect_state),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic result_t next_status(input logic [1:0] kind, input logic lvl);
    result_t r;
    logic started;
    started = 1'b0;
    case (kind)
      REQ_EDGE: begin
        if (!(rx_flag && tmo_left != 0)) begin
          case (fsm)
            ST_IDLE: begin
              if (!lvl) begin
                width_cnt = '0;
                width_run = 1'b1;
                fsm = ST_BREAK;
              end
            end
            ST_BREAK: begin
              if (lvl && width_cnt > brk_min && width_cnt < brk_max) begin
                light = 1'b1;
                fsm = ST_MARK;
                started = 1'b1;
                tmo_left = mark_tmo;
              end else begin
                fsm = ST_IDLE;
              end
              width_run = 1'b0;
            end
            ST_MARK: begin
              rx_flag = !lvl && (tmo_left != 0);
              fsm = ST_IDLE;
              light = 1'b0;
            end
            default: fsm = ST_IDLE;
          endcase
        end
      end
      REQ_WIDTH_TICK: begin
        if (width_run && width_cnt != '1) width_cnt = width_cnt + 1'b1;
      end
      REQ_MS_TICK: begin
        if (tmo_left != 0) tmo_left = tmo_left - 1'b1;
      end
      default: ;
    endcase
    r.receive_enable = rx_flag;
    r.frame_start = started;
    r.indicator = light;
    r.detect_state = fsm;
    return r;
  endfunction

  always @(posedge clk) begin : check_status
    result_t want;
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got = {receive_enable, frame_start, indicator, detect_state};
      if (status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: re=%0b fs=%0b ind=%0b st=%0d",
                   got.receive_enable, got.frame_start, got.indicator, got.detect_state);
      end else begin
        want = status_q.pop_front();
        if (got.receive_enable !== want.receive_enable || got.frame_start !== want.frame_start ||
            got.indicator !== want.indicator || got.detect_state !== want.detect_state) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected re=%0b fs=%0b ind=%0b st=%0d, got re=%0b fs=%0b ind=%0b st=%0d",
                     want.receive_enable, want.frame_start, want.indicator, want.detect_state,
                     got.receive_enable, got.frame_start, got.indicator, got.detect_state);
        end
      end
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic lvl);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    pin_level <= lvl;
    do @(posedge clk); while (!in_ready);
    status_q.push_back(next_status(kind, lvl));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BREAK_MIN: brk_min = data;
      CFG_BREAK_MAX: brk_max = data;
      CFG_MARK_TIMEOUT: mark_tmo = data[TIMEOUT_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [LIMIT_BITS-1:0] lo, input logic [LIMIT_BITS-1:0] hi,
                            input logic [TIMEOUT_BITS-1:0] tmo);
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    drain_results();
    write_reg(CFG_BREAK_MIN, lo);
    write_reg(CFG_BREAK_MAX, hi);
    write_reg(CFG_MARK_TIMEOUT, {junk, tmo});
  endtask

  task automatic send_frame();
    int unsigned k;
    int unsigned m;
    int unsigned lo;
    if (brk_max <= 250 && $urandom_range(1) == 1) begin
      k = $urandom_range(brk_max + 2, (brk_max > 2) ? brk_max - 2 : 0);
    end else begin
      lo = (brk_min > 2 && brk_min <= 250) ? brk_min - 2 : 0;
      k = $urandom_range(lo + 6, lo);
    end
    send_event(REQ_EDGE, 1'b0);
    repeat (k) begin
      send_event(REQ_WIDTH_TICK, 1'($urandom_range(1)));
      if ($urandom_range(15) == 0)
        send_event($urandom_range(1) ? REQ_MS_TICK : REQ_UNUSED, 1'($urandom_range(1)));
    end
    send_event(REQ_EDGE, $urandom_range(9) != 0);
    if ($urandom_range(1) == 1) m = $urandom_range(mark_tmo + 2, (mark_tmo > 2) ? mark_tmo - 2 : 0);
    else m = $urandom_range(3);
    repeat (m) send_event(REQ_MS_TICK, 1'($urandom_range(1)));
    send_event(REQ_EDGE, $urandom_range(6) == 0);
    if ($urandom_range(1) == 1) begin
      m = 32'(tmo_left);
      repeat (m) send_event(REQ_MS_TICK, 1'($urandom_range(1)));
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(6, 1);
    repeat (n) send_event(2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  task automatic test_directed();
    send_event(REQ_UNUSED, 1'b1);
    send_event(REQ_MS_TICK, 1'b1);
    send_event(REQ_WIDTH_TICK, 1'b0);
    send_event(REQ_EDGE, 1'b1);
    send_event(REQ_EDGE, 1'b0);
    send_event(REQ_EDGE, 1'b0);
    drain_results();
    write_reg(CFG_UNUSED, 16'hffff);
    write_reg(CFG_BREAK_MIN, 16'd1);
    write_reg(CFG_BREAK_MAX, 16'd4);
    write_reg(CFG_MARK_TIMEOUT, 16'hff03);
    // accepted break, early falling mark edge sets the flag
    send_event(REQ_EDGE, 1'b0);
    repeat (2) send_event(REQ_WIDTH_TICK, 1'b1);
    send_event(REQ_EDGE, 1'b1);
    send_event(REQ_MS_TICK, 1'b1);
    send_event(REQ_EDGE, 1'b0);
    // edges dropped while the flag holds and the timeout runs
    send_event(REQ_EDGE, 1'b0);
    send_event(REQ_EDGE, 1'b1);
    repeat (2) send_event(REQ_MS_TICK, 1'b0);
    // width equal to the upper limit is rejected
    send_event(REQ_EDGE, 1'b0);
    repeat (4) send_event(REQ_WIDTH_TICK, 1'b0);
    send_event(REQ_EDGE, 1'b1);
    // late mark edge clears the flag
    send_event(REQ_EDGE, 1'b0);
    repeat (2) send_event(REQ_WIDTH_TICK, 1'b0);
    send_event(REQ_EDGE, 1'b1);
    repeat (3) send_event(REQ_MS_TICK, 1'b0);
    send_event(REQ_EDGE, 1'b0);
    // rising mark edge
    send_event(REQ_EDGE, 1'b0);
    repeat (2) send_event(REQ_WIDTH_TICK, 1'b0);
    send_event(REQ_EDGE, 1'b1);
    send_event(REQ_EDGE, 1'b1);
  endtask

  task automatic test_random_traffic(input int phase);
    int unsigned stop_at;
    int cfg_n;
    logic [LIMIT_BITS-1:0] lo_lim;
    for (cfg_n = 0; cfg_n < 4; cfg_n++) begin
      lo_lim = LIMIT_BITS'($urandom_range(15));
      case (cfg_n)
        0: set_limits(BREAK_MIN_RESET, BREAK_MAX_RESET, MARK_TIMEOUT_RESET);
        1: set_limits(lo_lim, LIMIT_BITS'(lo_lim + $urandom_range(25, 1)),
                      TIMEOUT_BITS'($urandom_range(12)));
        2: set_limits(lo_lim, LIMIT_BITS'(lo_lim + $urandom_range(25, 1)), 8'd0);
        default: begin
          if (phase % 2 == 0) set_limits(16'h0000, 16'hffff, 8'hff);
          else set_limits(16'hffff, 16'h0000, 8'h00);
        end
      endcase
      stop_at = items_sent + 170;
      while (items_sent < stop_at) begin
        if ($urandom_range(39) == 0) drain_results();
        if ($urandom_range(3) != 0) send_frame();
        else send_noise();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_gap_pct = 22;
    stall_pct = 82;
    test_directed();
    test_random_traffic(0);
    send_gap_pct = 82;
    stall_pct = 22;
    test_random_traffic(1);
    send_gap_pct = 0;
    stall_pct = 0;
    test_random_traffic(2);
    drain_results();
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
